### sv/bfau_pkg.sv
// ----------------------------------------------------------------------------
// bfau_pkg
// Shared types, op codes and register indexes of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
package bfau_pkg;

	localparam int DEFAULT_FIELD_DEGREE = 173;
	localparam int ELEM_W = 173;
	localparam int WORD_W = 64;
	localparam int HIGH_W = 45;
	localparam int OP_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_ADD   = 3'd0;
	localparam logic [OP_W-1:0] OP_MUL   = 3'd1;
	localparam logic [OP_W-1:0] OP_SQR   = 3'd2;
	localparam logic [OP_W-1:0] OP_POW   = 3'd3;
	localparam logic [OP_W-1:0] OP_INV   = 3'd4;
	localparam logic [OP_W-1:0] OP_TRACE = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_MOD_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOD_HIGH = 2'd2;

	localparam logic [WORD_W-1:0] MOD_LOW_RST  = 64'd1031;
	localparam logic [WORD_W-1:0] MOD_MID_RST  = 64'd0;
	localparam logic [HIGH_W-1:0] MOD_HIGH_RST = 45'h1000_0000_0000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [HIGH_W-1:0] a_high;
		logic [WORD_W-1:0] a_mid;
		logic [WORD_W-1:0] a_low;
		logic [HIGH_W-1:0] b_high;
		logic [WORD_W-1:0] b_mid;
		logic [WORD_W-1:0] b_low;
	} in_t;

	typedef struct packed {
		logic [HIGH_W-1:0] res_high;
		logic [WORD_W-1:0] res_mid;
		logic [WORD_W-1:0] res_low;
	} out_t;

	typedef enum logic [2:0] {
		MS_AB,
		MS_AA,
		MS_RR,
		MS_A_ACC,
		MS_ACC_ACC
	} mul_sel_t;

	typedef enum logic [2:0] {
		OUT_ZERO,
		OUT_XOR,
		OUT_ACC,
		OUT_RES,
		OUT_SUM
	} out_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     mul_step;
		logic     res_from_acc;
		logic     sum_add;
		logic     exp_adv;
		logic     out_load;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
		logic ecnt_zero;
		logic exp_msb;
	} stat_t;

endpackage

### sv/binary_field_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// binary_field_arithmetic_unit: GF(2^m) arithmetic, one request at a time.
// Every op passes dispatch and finish; mul/square run one multiply, pow/inverse
// a square per exponent bit plus a multiply per set bit, and trace m-1
// squarings. The bit-serial multiplier works one bit per cycle.
// Reset clears the sequencer and output valid and restores the modulus.
// ----------------------------------------------------------------------------
module binary_field_arithmetic_unit #(
	parameter int FIELD_DEGREE = bfau_pkg::DEFAULT_FIELD_DEGREE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bfau_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfau_pkg::WORD_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  bfau_pkg::in_t                  in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output bfau_pkg::out_t                 out_data
);

	bfau_pkg::cmd_t  cmd;
	bfau_pkg::stat_t stat;

	bfau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (in_data.op),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	bfau_datapath #(
		.FIELD_DEGREE (FIELD_DEGREE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule

### sv/bfau_datapath.sv
// ----------------------------------------------------------------------------
// bfau_datapath
// Modulus registers, operand and exponent registers, bit-serial multiplier
// and result register of the GF(2^m) arithmetic unit.
// ----------------------------------------------------------------------------
module bfau_datapath #(
	parameter int FIELD_DEGREE = bfau_pkg::DEFAULT_FIELD_DEGREE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bfau_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bfau_pkg::WORD_W-1:0]      cfg_data,
	input  bfau_pkg::in_t                    in_data,
	input  bfau_pkg::cmd_t                   cmd,
	output bfau_pkg::stat_t                  stat,
	output bfau_pkg::out_t                   out_data
);

	localparam int EXT_W = (FIELD_DEGREE > bfau_pkg::ELEM_W) ? FIELD_DEGREE : bfau_pkg::ELEM_W;
	localparam int CNT_W = $clog2(FIELD_DEGREE);

	typedef logic [FIELD_DEGREE-1:0] elem_t;

	function automatic elem_t to_elem(logic [bfau_pkg::ELEM_W-1:0] v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return e[FIELD_DEGREE-1:0];
	endfunction

	// multiply by x; the x^m term is implied, so fold the low modulus bits in
	function automatic elem_t times_x(elem_t x, elem_t m);
		elem_t r;
		r = {x[FIELD_DEGREE-2:0], 1'b0};
		if (x[FIELD_DEGREE-1]) begin
			r = r ^ m;
		end
		return r;
	endfunction

	logic [bfau_pkg::WORD_W-1:0] mod_low_q;
	logic [bfau_pkg::WORD_W-1:0] mod_mid_q;
	logic [bfau_pkg::HIGH_W-1:0] mod_high_q;
	elem_t                       modulus;

	elem_t           base_q;
	elem_t           exp_q;
	elem_t           res_q;
	elem_t           sum_q;
	elem_t           mx_q;
	elem_t           my_q;
	elem_t           acc_q;
	logic [CNT_W-1:0] mcnt_q;
	logic [CNT_W-1:0] ecnt_q;
	bfau_pkg::out_t  out_q;

	elem_t            a_in;
	elem_t            b_in;
	elem_t            inv_exp;
	elem_t            mx_d;
	elem_t            my_d;
	elem_t            out_sel_val;
	logic [EXT_W-1:0] out_ext;

	assign modulus = to_elem({mod_high_q, mod_mid_q, mod_low_q});
	assign a_in    = to_elem({in_data.a_high, in_data.a_mid, in_data.a_low});
	assign b_in    = to_elem({in_data.b_high, in_data.b_mid, in_data.b_low});
	assign inv_exp = {{(FIELD_DEGREE-1){1'b1}}, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_low_q  <= bfau_pkg::MOD_LOW_RST;
			mod_mid_q  <= bfau_pkg::MOD_MID_RST;
			mod_high_q <= bfau_pkg::MOD_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bfau_pkg::CFG_MOD_LOW:  mod_low_q  <= cfg_data;
				bfau_pkg::CFG_MOD_MID:  mod_mid_q  <= cfg_data;
				bfau_pkg::CFG_MOD_HIGH: mod_high_q <= cfg_data[bfau_pkg::HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.mul_sel)
			bfau_pkg::MS_AB: begin
				mx_d = base_q;
				my_d = exp_q;
			end
			bfau_pkg::MS_AA: begin
				mx_d = base_q;
				my_d = base_q;
			end
			bfau_pkg::MS_RR: begin
				mx_d = res_q;
				my_d = res_q;
			end
			bfau_pkg::MS_A_ACC: begin
				mx_d = base_q;
				my_d = acc_q;
			end
			bfau_pkg::MS_ACC_ACC: begin
				mx_d = acc_q;
				my_d = acc_q;
			end
			default: begin
				mx_d = acc_q;
				my_d = acc_q;
			end
		endcase
	end

	always_comb begin
		case (cmd.out_sel)
			bfau_pkg::OUT_XOR: out_sel_val = base_q ^ exp_q;
			bfau_pkg::OUT_ACC: out_sel_val = acc_q;
			bfau_pkg::OUT_RES: out_sel_val = res_q;
			bfau_pkg::OUT_SUM: out_sel_val = sum_q;
			default:           out_sel_val = '0;
		endcase
	end

	assign out_ext = EXT_W'(out_sel_val);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= a_in;
			exp_q  <= (in_data.op == bfau_pkg::OP_INV) ? inv_exp : b_in;
			res_q  <= elem_t'(1);
			sum_q  <= a_in;
			ecnt_q <= (in_data.op == bfau_pkg::OP_TRACE) ? CNT_W'(FIELD_DEGREE - 2)
				: CNT_W'(FIELD_DEGREE - 1);
		end else begin
			if (cmd.res_from_acc) begin
				res_q <= acc_q;
			end
			if (cmd.sum_add) begin
				sum_q <= sum_q ^ acc_q;
			end
			if (cmd.exp_adv) begin
				exp_q  <= {exp_q[FIELD_DEGREE-2:0], 1'b0};
				ecnt_q <= ecnt_q - 1'b1;
			end
		end

		if (cmd.mul_start) begin
			mx_q   <= mx_d;
			my_q   <= my_d;
			acc_q  <= '0;
			mcnt_q <= '0;
		end else if (cmd.mul_step) begin
			if (my_q[0]) begin
				acc_q <= acc_q ^ mx_q;
			end
			mx_q   <= times_x(mx_q, modulus);
			my_q   <= my_q >> 1;
			mcnt_q <= mcnt_q + 1'b1;
		end

		if (cmd.out_load) begin
			out_q <= bfau_pkg::out_t'(out_ext[bfau_pkg::ELEM_W-1:0]);
		end
	end

	assign stat.mul_last  = (mcnt_q == CNT_W'(FIELD_DEGREE - 1));
	assign stat.ecnt_zero = (ecnt_q == '0);
	assign stat.exp_msb   = exp_q[FIELD_DEGREE-1];
	assign out_data       = out_q;

endmodule

### sv/bfau_ctrl.sv
// ----------------------------------------------------------------------------
// bfau_ctrl
// Sequencer: runs the multiplies each op needs and hands results to the output.
// ----------------------------------------------------------------------------
module bfau_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [bfau_pkg::OP_W-1:0]     op,
	input  logic                          out_stall,
	input  bfau_pkg::stat_t               stat,
	output bfau_pkg::cmd_t                cmd,
	output logic                          in_stall,
	output logic                          out_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_MUL,
		S_MUL_END,
		S_FINISH
	} state_t;

	state_t                    state_q;
	state_t                    nxt;
	logic [bfau_pkg::OP_W-1:0] op_q;
	logic                      phase_q;
	logic                      phase_d;
	logic                      out_valid_q;

	always_comb begin
		cmd     = '0;
		nxt     = state_q;
		phase_d = phase_q;

		case (op_q)
			bfau_pkg::OP_ADD:   cmd.out_sel = bfau_pkg::OUT_XOR;
			bfau_pkg::OP_MUL,
			bfau_pkg::OP_SQR:   cmd.out_sel = bfau_pkg::OUT_ACC;
			bfau_pkg::OP_POW,
			bfau_pkg::OP_INV:   cmd.out_sel = bfau_pkg::OUT_RES;
			bfau_pkg::OP_TRACE: cmd.out_sel = bfau_pkg::OUT_SUM;
			default:            cmd.out_sel = bfau_pkg::OUT_ZERO;
		endcase

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				nxt = S_MUL;
				phase_d = 1'b0;
				cmd.mul_start = 1'b1;
				case (op_q)
					bfau_pkg::OP_MUL: cmd.mul_sel = bfau_pkg::MS_AB;
					bfau_pkg::OP_SQR,
					bfau_pkg::OP_TRACE: cmd.mul_sel = bfau_pkg::MS_AA;
					bfau_pkg::OP_POW,
					bfau_pkg::OP_INV: cmd.mul_sel = bfau_pkg::MS_RR;
					default: begin
						cmd.mul_start = 1'b0;
						nxt = S_FINISH;
					end
				endcase
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last) begin
					nxt = S_MUL_END;
				end
			end
			S_MUL_END: begin
				case (op_q)
					bfau_pkg::OP_POW,
					bfau_pkg::OP_INV: begin
						cmd.res_from_acc = 1'b1;
						if (!phase_q && stat.exp_msb) begin
							// exponent bit set: multiply the square by the base
							cmd.mul_start = 1'b1;
							cmd.mul_sel = bfau_pkg::MS_A_ACC;
							phase_d = 1'b1;
							nxt = S_MUL;
						end else if (stat.ecnt_zero) begin
							nxt = S_FINISH;
						end else begin
							cmd.exp_adv = 1'b1;
							cmd.mul_start = 1'b1;
							cmd.mul_sel = bfau_pkg::MS_ACC_ACC;
							phase_d = 1'b0;
							nxt = S_MUL;
						end
					end
					bfau_pkg::OP_TRACE: begin
						cmd.res_from_acc = 1'b1;
						cmd.sum_add = 1'b1;
						if (stat.ecnt_zero) begin
							nxt = S_FINISH;
						end else begin
							cmd.exp_adv = 1'b1;
							cmd.mul_start = 1'b1;
							cmd.mul_sel = bfau_pkg::MS_ACC_ACC;
							nxt = S_MUL;
						end
					end
					default: nxt = S_FINISH;
				endcase
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= bfau_pkg::OP_ADD;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			phase_q <= phase_d;
			if (cmd.load) begin
				op_q <= op;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

### sv/bfau_checker.sv
// ----------------------------------------------------------------------------
// bfau_checker
// Port-level checks of the GF(2^m) arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module bfau_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input bfau_pkg::out_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

	// a new result shows up only as the unit goes idle
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result issued while still busy");

	// a result never rises on out_valid right after its request is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result too early");

endmodule

bind binary_field_arithmetic_unit bfau_checker u_bfau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

### sim/tb_binary_field_arithmetic_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_field_arithmetic_unit
// Self-checking bench for the GF(2^m) arithmetic unit. A short table of
// directed requests (field extremes, every op, zero exponent, inverse and
// trace of trivial elements, unused op codes) runs first, then random
// requests under five modulus settings. Results are checked in order against
// fixed values or a bit-serial predictor kept inside the bench. Both handshakes idle and
// stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_binary_field_arithmetic_unit;

	localparam int FIELD_DEGREE = bfau_pkg::DEFAULT_FIELD_DEGREE;
	localparam int VEC_W = 192;
	localparam int LONG_HOLD = 1500;
	localparam int IDLE_LIMIT = 250000;
	localparam int DRAIN_CYCLES = 8;
	localparam int ITEMS_PER_PHASE = 14;
	localparam int BURST_LEN = 8;

	localparam logic [bfau_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [bfau_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;
	localparam logic [bfau_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef bit [VEC_W-1:0] gf_elem_t;

	localparam gf_elem_t FIELD_MASK = {VEC_W{1'b1}} >> (VEC_W - FIELD_DEGREE);
	localparam gf_elem_t ELEM_ONE = gf_elem_t'(1);
	localparam gf_elem_t ELEM_X = gf_elem_t'(2);
	localparam gf_elem_t ELEM_TOP = gf_elem_t'(1) << (FIELD_DEGREE - 1);
	localparam gf_elem_t ELEM_MIX =
		192'h5a5a_0f0f_1234_5678_9abc_def0_0fed_cba9_8765_4321_a5a5_c3c3 & FIELD_MASK;

	typedef struct {
		bfau_pkg::in_t  req;
		bit             has_fixed;
		bfau_pkg::out_t fixed_res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bfau_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bfau_pkg::WORD_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	bfau_pkg::in_t in_data;
	logic out_valid;
	logic out_stall;
	bfau_pkg::out_t out_data;

	// predictor copy of the modulus registers
	logic [bfau_pkg::WORD_W-1:0] mod_low;
	logic [bfau_pkg::WORD_W-1:0] mod_mid;
	logic [bfau_pkg::HIGH_W-1:0] mod_high;

	bfau_pkg::out_t pending_results[$];
	dir_row_t dir_rows[$];
	int mismatches;
	int idle_cycles;
	int op_count[8];
	bit quiet;
	bit hold_req;
	int stall_left;

	binary_field_arithmetic_unit #(
		.FIELD_DEGREE(FIELD_DEGREE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------- field arithmetic predictor ----------------

	function automatic gf_elem_t mul_by_x(gf_elem_t v);
		gf_elem_t r;
		gf_elem_t m;
		r = v << 1;
		m = '0;
		m[bfau_pkg::ELEM_W-1:0] = {mod_high, mod_mid, mod_low};
		// drop x^m and fold in the low modulus bits
		if (r[FIELD_DEGREE])
			r = (r & FIELD_MASK) ^ (m & FIELD_MASK);
		return r & FIELD_MASK;
	endfunction

	function automatic gf_elem_t field_mul(gf_elem_t a, gf_elem_t b);
		gf_elem_t acc;
		acc = '0;
		for (int i = 0; i < FIELD_DEGREE; i++) begin
			if (b[i])
				acc ^= a;
			a = mul_by_x(a);
		end
		return acc;
	endfunction

	function automatic gf_elem_t field_pow(gf_elem_t a, gf_elem_t e);
		gf_elem_t acc;
		acc = ELEM_ONE;
		for (int i = FIELD_DEGREE; i > 0; i--) begin
			acc = field_mul(acc, acc);
			if (e[i-1])
				acc = field_mul(a, acc);
		end
		return acc;
	endfunction

	function automatic gf_elem_t field_trace(gf_elem_t a);
		gf_elem_t acc;
		gf_elem_t t;
		acc = a;
		t = a;
		for (int i = 1; i < FIELD_DEGREE; i++) begin
			t = field_mul(t, t);
			acc ^= t;
		end
		return acc;
	endfunction

	function automatic bfau_pkg::out_t to_out(gf_elem_t r);
		bfau_pkg::out_t o;
		o.res_low = r[bfau_pkg::WORD_W-1:0];
		o.res_mid = r[2*bfau_pkg::WORD_W-1:bfau_pkg::WORD_W];
		o.res_high = r[2*bfau_pkg::WORD_W +: bfau_pkg::HIGH_W];
		return o;
	endfunction

	function automatic bfau_pkg::in_t make_req(logic [bfau_pkg::OP_W-1:0] op, gf_elem_t a,
			gf_elem_t b);
		bfau_pkg::in_t q;
		q.op = op;
		q.a_low = a[bfau_pkg::WORD_W-1:0];
		q.a_mid = a[2*bfau_pkg::WORD_W-1:bfau_pkg::WORD_W];
		q.a_high = a[2*bfau_pkg::WORD_W +: bfau_pkg::HIGH_W];
		q.b_low = b[bfau_pkg::WORD_W-1:0];
		q.b_mid = b[2*bfau_pkg::WORD_W-1:bfau_pkg::WORD_W];
		q.b_high = b[2*bfau_pkg::WORD_W +: bfau_pkg::HIGH_W];
		return q;
	endfunction

	function automatic bfau_pkg::out_t predict_field_op(bfau_pkg::in_t q);
		gf_elem_t a;
		gf_elem_t b;
		gf_elem_t r;
		a = '0;
		b = '0;
		a[bfau_pkg::ELEM_W-1:0] = {q.a_high, q.a_mid, q.a_low};
		b[bfau_pkg::ELEM_W-1:0] = {q.b_high, q.b_mid, q.b_low};
		a &= FIELD_MASK;
		b &= FIELD_MASK;
		case (q.op)
			bfau_pkg::OP_ADD: r = a ^ b;
			bfau_pkg::OP_MUL: r = field_mul(a, b);
			bfau_pkg::OP_SQR: r = field_mul(a, a);
			bfau_pkg::OP_POW: r = field_pow(a, b);
			bfau_pkg::OP_INV: r = field_pow(a, FIELD_MASK & ~ELEM_ONE);
			bfau_pkg::OP_TRACE: r = field_trace(a);
			default: r = '0;
		endcase
		return to_out(r);
	endfunction

	// ---------------- random picks ----------------

	function automatic gf_elem_t rand_elem();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return ELEM_ONE;
			2: return FIELD_MASK;
			3: return gf_elem_t'(1) << $urandom_range(0, FIELD_DEGREE - 1);
			default: return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}
				& FIELD_MASK;
		endcase
	endfunction

	// keep the slow ops rare: pow and inverse run a multiply per exponent bit
	function automatic logic [bfau_pkg::OP_W-1:0] rand_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return bfau_pkg::OP_ADD;
		if (r < 62) return bfau_pkg::OP_MUL;
		if (r < 86) return bfau_pkg::OP_SQR;
		if (r < 89) return bfau_pkg::OP_POW;
		if (r < 90) return bfau_pkg::OP_INV;
		if (r < 92) return bfau_pkg::OP_TRACE;
		if (r < 96) return OP_SPARE6;
		return OP_SPARE7;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	function automatic int pick_run();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 10);
		return $urandom_range(50, 300);
	endfunction

	// ---------------- stimulus helpers ----------------

	task automatic add_row(logic [bfau_pkg::OP_W-1:0] op, gf_elem_t a, gf_elem_t b,
			bit has_fixed, gf_elem_t fixed_val);
		dir_row_t row;
		row.req = make_req(op, a, b);
		row.has_fixed = has_fixed;
		row.fixed_res = to_out(fixed_val);
		dir_rows.push_back(row);
	endtask

	task automatic send_request(bfau_pkg::in_t req, bit has_fixed,
			bfau_pkg::out_t fixed_res, int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= req;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_results.push_back(has_fixed ? fixed_res : predict_field_op(req));
		op_count[req.op]++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_cfg(logic [bfau_pkg::CFG_IDX_W-1:0] idx,
			logic [bfau_pkg::WORD_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			bfau_pkg::CFG_MOD_LOW: mod_low = data;
			bfau_pkg::CFG_MOD_MID: mod_mid = data;
			bfau_pkg::CFG_MOD_HIGH: mod_high = data[bfau_pkg::HIGH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_modulus(logic [bfau_pkg::WORD_W-1:0] lo,
			logic [bfau_pkg::WORD_W-1:0] mid, logic [bfau_pkg::WORD_W-1:0] hi);
		write_cfg(bfau_pkg::CFG_MOD_LOW, lo);
		write_cfg(bfau_pkg::CFG_MOD_MID, mid);
		write_cfg(bfau_pkg::CFG_MOD_HIGH, hi);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(int count);
		logic [bfau_pkg::OP_W-1:0] op;
		for (int i = 0; i < count; i++) begin
			op = rand_op();
			send_request(make_req(op, rand_elem(), rand_elem()), 1'b0, '0, pick_gap());
		end
	endtask

	// ---------------- receiver: random stall plus one long hold-off ----------------

	initial begin
		out_stall = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				stall_left = 0;
				out_stall <= 1'b0;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
				stall_left = pick_run();
			end
		end
	end

	// ---------------- result check ----------------

	always @(posedge clk) begin : check_results
		bfau_pkg::out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no request pending: %h", $time, out_data);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_data.res_low !== want.res_low) begin
					$display("%0t: res_low expected %h actual %h", $time,
						want.res_low, out_data.res_low);
					mismatches++;
				end
				if (out_data.res_mid !== want.res_mid) begin
					$display("%0t: res_mid expected %h actual %h", $time,
						want.res_mid, out_data.res_mid);
					mismatches++;
				end
				if (out_data.res_high !== want.res_high) begin
					$display("%0t: res_high expected %h actual %h", $time,
						want.res_high, out_data.res_high);
					mismatches++;
				end
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
			$display("tb_binary_field_arithmetic_unit: errors");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		mismatches = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		mod_low = bfau_pkg::MOD_LOW_RST;
		mod_mid = bfau_pkg::MOD_MID_RST;
		mod_high = bfau_pkg::MOD_HIGH_RST;

		add_row(bfau_pkg::OP_ADD, FIELD_MASK, '0, 1'b1, FIELD_MASK);
		add_row(bfau_pkg::OP_ADD, FIELD_MASK, FIELD_MASK, 1'b1, '0);
		add_row(bfau_pkg::OP_ADD, ELEM_MIX, ELEM_TOP, 1'b0, '0);
		add_row(bfau_pkg::OP_MUL, ELEM_MIX, ELEM_ONE, 1'b1, ELEM_MIX);
		add_row(bfau_pkg::OP_MUL, FIELD_MASK, '0, 1'b1, '0);
		add_row(bfau_pkg::OP_MUL, FIELD_MASK, FIELD_MASK, 1'b0, '0);
		add_row(bfau_pkg::OP_MUL, ELEM_TOP, ELEM_X, 1'b0, '0);
		add_row(bfau_pkg::OP_MUL, ELEM_TOP, ELEM_TOP, 1'b0, '0);
		add_row(bfau_pkg::OP_SQR, FIELD_MASK, '0, 1'b0, '0);
		add_row(bfau_pkg::OP_SQR, '0, FIELD_MASK, 1'b1, '0);
		add_row(bfau_pkg::OP_POW, '0, '0, 1'b1, ELEM_ONE);
		add_row(bfau_pkg::OP_POW, FIELD_MASK, '0, 1'b1, ELEM_ONE);
		add_row(bfau_pkg::OP_POW, ELEM_X, FIELD_MASK, 1'b0, '0);
		add_row(bfau_pkg::OP_POW, ELEM_MIX, gf_elem_t'(5), 1'b0, '0);
		add_row(bfau_pkg::OP_INV, '0, FIELD_MASK, 1'b1, '0);
		add_row(bfau_pkg::OP_INV, ELEM_ONE, '0, 1'b1, ELEM_ONE);
		add_row(bfau_pkg::OP_INV, ELEM_X, '0, 1'b0, '0);
		add_row(bfau_pkg::OP_TRACE, '0, '0, 1'b1, '0);
		add_row(bfau_pkg::OP_TRACE, ELEM_ONE, '0, 1'b1, gf_elem_t'(FIELD_DEGREE & 1));
		add_row(bfau_pkg::OP_TRACE, FIELD_MASK, '0, 1'b0, '0);
		add_row(OP_SPARE6, FIELD_MASK, FIELD_MASK, 1'b1, '0);
		add_row(OP_SPARE7, FIELD_MASK, FIELD_MASK, 1'b1, '0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].has_fixed, dir_rows[i].fixed_res,
				pick_gap());
		drain();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					// spare index: must leave the modulus untouched
					write_cfg(CFG_SPARE, {$urandom, $urandom});
					cfg_we <= 1'b0;
				end
				1: begin
					set_modulus('1, '1, '1);
					quiet = 1'b1;
				end
				2: set_modulus('0, '0, '0);
				3: set_modulus({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom});
				default: set_modulus(bfau_pkg::MOD_LOW_RST ^ {$urandom, $urandom}, '0,
					{$urandom, $urandom});
			endcase
			@(posedge clk);
			if (phase == 2) begin
				// hold the output so the unit backs up into its input
				hold_req = 1'b1;
				for (int k = 0; k < BURST_LEN; k++)
					send_request(make_req(bfau_pkg::OP_ADD, rand_elem(), rand_elem()),
						1'b0, '0, 0);
			end
			send_random(ITEMS_PER_PHASE);
			drain();
			quiet = 1'b0;
		end

		$display("covered %0d add, %0d mul, %0d square, %0d pow, %0d inverse,",
			op_count[bfau_pkg::OP_ADD], op_count[bfau_pkg::OP_MUL],
			op_count[bfau_pkg::OP_SQR], op_count[bfau_pkg::OP_POW],
			op_count[bfau_pkg::OP_INV]);
		$display("%0d trace, %0d spare; moduli: reset, all ones, zero, two random",
			op_count[bfau_pkg::OP_TRACE], op_count[OP_SPARE6] + op_count[OP_SPARE7]);
		if (mismatches == 0)
			$display("tb_binary_field_arithmetic_unit: clean");
		else
			$display("tb_binary_field_arithmetic_unit: errors");
		$finish;
	end

endmodule

### files.f
sv/bfau_pkg.sv
sv/bfau_datapath.sv
sv/bfau_ctrl.sv
sv/binary_field_arithmetic_unit.sv
sv/bfau_checker.sv
sim/tb_binary_field_arithmetic_unit.sv
